>>> hw/rtl/fcca_pkg.sv
// Shared types and constants for the FAT16 cluster chain allocator.
// No dependencies; imported by fcca_table_ram and fat16_cluster_chain_allocator.
`default_nettype none

package fcca_pkg;

    localparam int unsigned FCCA_TABLE_DEPTH = 4096;
    localparam int unsigned FCCA_CFG_W       = 13;
    localparam int unsigned FCCA_ENTRY_W     = 16;
    localparam logic [12:0] FCCA_CFG_RESET   = 13'd4096;

    localparam logic [15:0] FCCA_END_OF_CHAIN = 16'hFFFF;
    localparam logic [15:0] FCCA_END_MARK_MIN = 16'hFFF8;
    localparam logic [15:0] FCCA_FIRST_DATA   = 16'd2;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_READ  = 2'd1,
        OP_ALLOC = 2'd2,
        OP_FREE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_RD_WAIT,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_ALLOC_LINK,
        S_FREE_CHK,
        S_FREE_DATA,
        S_RESP
    } t_state;

    // single-port table access: one read or one write per cycle
    typedef struct packed {
        logic        we;
        logic        re;
        logic [15:0] addr;
        logic [15:0] wdata;
    } t_ram_req;

endpackage

`default_nettype wire

>>> hw/rtl/fat16_cluster_chain_allocator.sv
// Top level: FAT16 cluster table sequencer (load, read, allocate, free chain).
// Depends on fcca_pkg and fcca_table_ram.
//
// channel   dir  handshake                 word
// s_axis    in   s_axis_tvalid/tready      tuser: operation; tdata: index, value, link
// m_axis    out  m_axis_tvalid/tready      tdata: result_value, status, freed_count
// cfg       in   i_cfg_valid/o_cfg_ready   i_cfg_data: entries_in_use
//
// Load writes at dispatch; read has a wait state. Allocate scans from cluster 2 for a
// free entry, marks it end of chain and, if asked, links the previous cluster to it,
// or reports a full table. Free clears entries until the chain end, bound or a bad link.
// Single table port, one access per cycle; entry count is written only while idle.
// Sync active-low reset clears control state; table contents are undefined until loaded.
// A new word is taken once the result has moved into the output register.
`default_nettype none

module fat16_cluster_chain_allocator #(
    parameter int unsigned TABLE_DEPTH = fcca_pkg::FCCA_TABLE_DEPTH
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // [15:0] cluster_index, [31:16] entry_value, [32] link_previous, [39:33] zero
    input  wire  [39:0] s_axis_tdata,
    // [1:0] operation
    input  wire  [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // [15:0] result_value, [17:16] status, [30:18] freed_count, [31] zero
    output logic [31:0] m_axis_tdata,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [12:0] i_cfg_data
);
    import fcca_pkg::*;

    localparam logic [16:0] DEPTH17 = 17'(TABLE_DEPTH);

    t_state      r_state, n_state;
    t_op         r_op;
    logic [15:0] r_idx;
    logic [15:0] r_val;
    logic        r_link;
    logic [12:0] r_entries;
    logic [12:0] r_scan, n_scan;
    logic [15:0] r_cur, n_cur;
    logic [12:0] r_count, n_count;
    logic [15:0] r_result, n_result;
    t_status     r_status, n_status;
    logic        r_out_valid;
    logic [31:0] r_out_data;

    t_ram_req    w_req;
    logic [15:0] w_rdata;
    logic [12:0] w_limit;
    logic        w_idx_ok;
    logic        w_cur_ok;
    logic        w_accept;
    logic        w_out_free;
    logic        w_chain_end;

    fcca_table_ram #(
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_req   (w_req),
        .o_rdata (w_rdata)
    );

    assign w_limit     = ({4'b0, r_entries} < DEPTH17) ? r_entries : DEPTH17[12:0];
    assign w_idx_ok    = {1'b0, r_idx} < DEPTH17;
    assign w_cur_ok    = {1'b0, r_cur} < DEPTH17;
    assign w_accept    = s_axis_tvalid && s_axis_tready;
    assign w_out_free  = !r_out_valid || m_axis_tready;
    assign w_chain_end = (w_rdata >= FCCA_END_MARK_MIN) || (w_rdata < FCCA_FIRST_DATA);

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                case (r_op)
                    OP_LOAD:  n_state = S_RESP;
                    OP_READ:  n_state = w_idx_ok ? S_RD_WAIT : S_RESP;
                    OP_ALLOC: n_state = (r_link && !w_idx_ok) ? S_RESP : S_SCAN_RD;
                    default:  n_state = S_FREE_CHK;
                endcase
            end
            S_RD_WAIT:    n_state = S_RESP;
            S_SCAN_RD:    n_state = (r_scan < w_limit) ? S_SCAN_CMP : S_RESP;
            S_SCAN_CMP: begin
                if (w_rdata == 16'd0) n_state = r_link ? S_ALLOC_LINK : S_RESP;
                else n_state = S_SCAN_RD;
            end
            S_ALLOC_LINK: n_state = S_RESP;
            S_FREE_CHK: begin
                if (r_count >= w_limit || !w_cur_ok) n_state = S_RESP;
                else n_state = S_FREE_DATA;
            end
            S_FREE_DATA:  n_state = w_chain_end ? S_RESP : S_FREE_CHK;
            S_RESP: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default:      n_state = S_IDLE;
        endcase
    end

    // table port and working registers
    always_comb begin
        w_req    = '0;
        n_scan   = r_scan;
        n_cur    = r_cur;
        n_count  = r_count;
        n_result = r_result;
        n_status = r_status;
        case (r_state)
            S_DISPATCH: begin
                n_scan = FCCA_FIRST_DATA[12:0];
                n_cur  = r_idx;
                case (r_op)
                    OP_LOAD: begin
                        if (w_idx_ok) begin
                            w_req.we    = 1'b1;
                            w_req.addr  = r_idx;
                            w_req.wdata = r_val;
                        end else begin
                            n_status = ST_RANGE;
                        end
                    end
                    OP_READ: begin
                        if (w_idx_ok) begin
                            w_req.re   = 1'b1;
                            w_req.addr = r_idx;
                        end else begin
                            n_status = ST_RANGE;
                        end
                    end
                    OP_ALLOC: begin
                        if (r_link && !w_idx_ok) n_status = ST_RANGE;
                    end
                    default: ;
                endcase
            end
            S_RD_WAIT: n_result = w_rdata;
            S_SCAN_RD: begin
                if (r_scan < w_limit) begin
                    w_req.re   = 1'b1;
                    w_req.addr = {3'b0, r_scan};
                end else begin
                    n_status = ST_FULL;
                end
            end
            S_SCAN_CMP: begin
                if (w_rdata == 16'd0) begin
                    w_req.we    = 1'b1;
                    w_req.addr  = {3'b0, r_scan};
                    w_req.wdata = FCCA_END_OF_CHAIN;
                    n_result    = {3'b0, r_scan};
                end else begin
                    n_scan = r_scan + 13'd1;
                end
            end
            S_ALLOC_LINK: begin
                w_req.we    = 1'b1;
                w_req.addr  = r_idx;
                w_req.wdata = {3'b0, r_scan};
            end
            S_FREE_CHK: begin
                if (r_count < w_limit) begin
                    if (w_cur_ok) begin
                        w_req.re   = 1'b1;
                        w_req.addr = r_cur;
                    end else begin
                        n_status = ST_RANGE;
                    end
                end
            end
            S_FREE_DATA: begin
                w_req.we    = 1'b1;
                w_req.addr  = r_cur;
                w_req.wdata = 16'd0;
                n_count     = r_count + 13'd1;
                n_cur       = w_rdata;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_entries   <= FCCA_CFG_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) r_entries <= i_cfg_data;
            if (r_state == S_RESP && w_out_free) r_out_valid <= 1'b1;
            else if (m_axis_tready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op     <= t_op'(s_axis_tuser);
            r_idx    <= s_axis_tdata[15:0];
            r_val    <= s_axis_tdata[31:16];
            r_link   <= s_axis_tdata[32];
            r_scan   <= 13'd0;
            r_cur    <= 16'd0;
            r_count  <= 13'd0;
            r_result <= 16'd0;
            r_status <= ST_OK;
        end else begin
            r_scan   <= n_scan;
            r_cur    <= n_cur;
            r_count  <= n_count;
            r_result <= n_result;
            r_status <= n_status;
        end
        if (r_state == S_RESP && w_out_free) begin
            r_out_data <= {1'b0, r_count, r_status, r_result};
        end
    end

    a_accept_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_DISPATCH))
        else $error("accepted word did not start dispatch");

    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req.we |-> (r_state == S_DISPATCH || r_state == S_SCAN_CMP ||
                      r_state == S_ALLOC_LINK || r_state == S_FREE_DATA))
        else $error("table write outside a writing step");

    a_scan_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN_CMP) |-> (r_scan >= FCCA_FIRST_DATA[12:0]))
        else $error("allocate scan below first data cluster");

    a_resp_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESP && !r_out_valid) |=> r_out_valid)
        else $error("result not moved to output register");

endmodule

`default_nettype wire

>>> hw/rtl/fcca_table_ram.sv
// Single-port allocation table memory with registered read data.
// Depends on fcca_pkg (t_ram_req).
`default_nettype none

module fcca_table_ram #(
    parameter int unsigned DEPTH = 4096
) (
    input  wire                  i_clk,
    input  fcca_pkg::t_ram_req   i_req,
    output logic [15:0]          o_rdata
);
    import fcca_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);

    logic [FCCA_ENTRY_W-1:0] r_mem [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr[AW-1:0]] <= i_req.wdata;
        end
        if (i_req.re) begin
            o_rdata <= r_mem[i_req.addr[AW-1:0]];
        end
    end

endmodule

`default_nettype wire
